// ===== sv/abp_pkg.sv =====
package abp_pkg;

    // field and state formats
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;
    localparam int STATE_BITS  = 32;
    localparam int FRAC_BITS   = COEF_BITS - 3;

    // digit-serial multiplier geometry
    localparam int DIGIT_BITS = 8;
    localparam int NUM_DIGITS = (COEF_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int CSR_BITS   = NUM_DIGITS * DIGIT_BITS;
    localparam int OPND_BITS  = SAMPLE_BITS + 1;
    localparam int PART_BITS  = DIGIT_BITS + 1 + OPND_BITS;
    localparam int ACC_BITS   = (OPND_BITS + DIGIT_BITS + 2 > COEF_BITS)
                              ? (OPND_BITS + DIGIT_BITS + 2) : COEF_BITS;
    localparam int Q_BITS     = ACC_BITS + CSR_BITS - FRAC_BITS;
    localparam int SUM_BITS   = ((Q_BITS > STATE_BITS) ? Q_BITS : STATE_BITS) + 1;
    localparam int CNT_BITS   = $clog2(NUM_DIGITS + 1);

    // configuration register map
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_A1 = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_A2 = CFG_INDEX_BITS'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        STEP_Y,
        STEP_N1,
        STEP_N2
    } step_t;

    typedef struct packed {
        logic load;
        logic run;
    } mac_ctrl_t;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SUM_BITS-1:0] v
    );
        logic signed [SUM_BITS-1:0] hi;
        logic signed [SUM_BITS-1:0] lo;
        hi = {{(SUM_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return hi[SAMPLE_BITS-1:0];
        else if (v < lo)
            return lo[SAMPLE_BITS-1:0];
        else
            return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [SUM_BITS-1:0] v
    );
        logic signed [SUM_BITS-1:0] hi;
        logic signed [SUM_BITS-1:0] lo;
        hi = {{(SUM_BITS-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return hi[STATE_BITS-1:0];
        else if (v < lo)
            return lo[STATE_BITS-1:0];
        else
            return v[STATE_BITS-1:0];
    endfunction

endpackage

// ===== sv/abp_if.sv =====
interface abp_in_if
    import abp_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          block_end_in;

    modport source (output valid, output sample_in, output block_end_in, input ready);
    modport sink   (input valid, input sample_in, input block_end_in, output ready);
endinterface

interface abp_out_if
    import abp_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          block_end_out;

    modport source (output valid, output sample_out, output block_end_out, input ready);
    modport sink   (input valid, input sample_out, input block_end_out, output ready);
endinterface

// ===== sv/abp_mac.sv =====
module abp_mac
    import abp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mac_ctrl_t                   ctrl,
    input  logic signed [COEF_BITS-1:0] coef,
    input  logic signed [OPND_BITS-1:0] opnd,
    output logic                        done,
    output logic signed [Q_BITS-1:0]    quot
);

    localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

    logic [CSR_BITS-1:0]        csr_reg, csr_next;
    logic signed [OPND_BITS-1:0] opnd_reg, opnd_next;
    logic signed [ACC_BITS-1:0] acc_reg, acc_next;
    logic [CSR_BITS-1:0]        lo_reg, lo_next;
    logic [CNT_BITS-1:0]        cnt_reg, cnt_next;

    logic [DIGIT_BITS-1:0]       digit;
    logic                        last;
    logic signed [DIGIT_BITS:0]  digit_s;
    logic signed [PART_BITS-1:0] part;
    logic signed [ACC_BITS-1:0]  acc_sum;

    // top digit of the coefficient carries the sign, the rest are unsigned
    always_comb
    begin
        digit   = csr_reg[DIGIT_BITS-1:0];
        last    = (cnt_reg == CNT_BITS'(NUM_DIGITS - 1));
        digit_s = last ? {digit[DIGIT_BITS-1], digit} : {1'b0, digit};
        part    = digit_s * opnd_reg;
        acc_sum = acc_reg + ACC_BITS'(part);
    end

    assign done = (cnt_reg == CNT_BITS'(NUM_DIGITS));
    assign quot = {acc_reg, lo_reg[CSR_BITS-1:FRAC_BITS]};

    always_comb
    begin
        csr_next  = csr_reg;
        opnd_next = opnd_reg;
        acc_next  = acc_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        if (ctrl.load)
        begin
            csr_next  = CSR_BITS'(coef);
            opnd_next = opnd;
            acc_next  = HALF;
            lo_next   = '0;
            cnt_next  = '0;
        end
        else if (ctrl.run && !done)
        begin
            csr_next = csr_reg >> DIGIT_BITS;
            acc_next = acc_sum >>> DIGIT_BITS;
            lo_next  = {acc_sum[DIGIT_BITS-1:0], lo_reg[CSR_BITS-1:DIGIT_BITS]};
            cnt_next = cnt_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= CNT_BITS'(NUM_DIGITS);
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        csr_reg  <= csr_next;
        opnd_reg <= opnd_next;
        acc_reg  <= acc_next;
        lo_reg   <= lo_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(NUM_DIGITS))
        else $error("digit count out of range");

    a_load_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> (cnt_reg == '0) && !done)
        else $error("load did not restart the multiplier");

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(ctrl.run))
        else $error("multiplier finished without running");

endmodule

// ===== sv/allpass_biquad_df2t_core.sv =====
// second-order allpass biquad, transposed direct form ii, one shared digit-serial multiplier
// input is taken only while idle, so a new sample waits until the last result has entered the output register
// the three products of a sample pass one after another through the single multiplier,
//   one coefficient digit a cycle
// reset: rst_n async active low, clears coefficients, both delay states and all handshakes
module allpass_biquad_df2t_core
    import abp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]      cfg_data,
    abp_in_if.sink                    in_ch,
    abp_out_if.source                 out_ch
);

    // configuration and filter state
    logic signed [COEF_BITS-1:0]   coef_a1_reg, coef_a1_next;
    logic signed [COEF_BITS-1:0]   coef_a2_reg, coef_a2_next;
    logic signed [STATE_BITS-1:0]  s1_reg, s1_next;
    logic signed [STATE_BITS-1:0]  s2_reg, s2_next;

    // sample being worked on
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic signed [SAMPLE_BITS-1:0] y_reg, y_next;
    logic                          mark_reg, mark_next;

    // sequencer
    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    // output register, parts the result from the input side
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic                          out_mark_reg, out_mark_next;

    logic                          in_xfer;
    logic                          out_free;
    mac_ctrl_t                     mac_ctrl;
    logic signed [COEF_BITS-1:0]   mac_coef;
    logic signed [OPND_BITS-1:0]   mac_opnd;
    logic                          mac_done;
    logic signed [Q_BITS-1:0]      mac_quot;
    logic signed [SUM_BITS-1:0]    base;
    logic signed [SUM_BITS-1:0]    sum;
    logic                          fin;

    assign in_ch.ready          = (state_reg == ST_IDLE);
    assign in_xfer              = in_ch.valid && in_ch.ready;
    // output slot can take a new result if empty or emptying this cycle
    assign out_free             = !out_valid_reg || out_ch.ready;
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.sample_out    = out_sample_reg;
    assign out_ch.block_end_out = out_mark_reg;

    // next state: per product load, run all digits, then fold into the target; after the third product, output
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_LOAD;
                    step_next  = STEP_Y;
                end
            end
            ST_LOAD:
                state_next = ST_MUL;
            ST_MUL:
            begin
                if (mac_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                unique case (step_reg)
                    STEP_Y:
                    begin
                        step_next  = STEP_N1;
                        state_next = ST_LOAD;
                    end
                    STEP_N1:
                    begin
                        step_next  = STEP_N2;
                        state_next = ST_LOAD;
                    end
                    STEP_N2:
                        state_next = ST_OUT;
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_OUT:
            begin
                // wait for room in the output register
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs to the multiplier
    always_comb
    begin
        mac_ctrl.load = (state_reg == ST_LOAD);
        mac_ctrl.run  = (state_reg == ST_MUL);
        fin           = (state_reg == ST_FIN);
    end

    // operand and accumulation base per product:
    //   y  = s1 + a2*x
    //   s1 = s2 + a1*(x - y)
    //   s2 = x  + a2*(-y)
    always_comb
    begin
        unique case (step_reg)
            STEP_Y:
            begin
                mac_coef = coef_a2_reg;
                mac_opnd = OPND_BITS'(x_reg);
                base     = SUM_BITS'(s1_reg);
            end
            STEP_N1:
            begin
                mac_coef = coef_a1_reg;
                mac_opnd = OPND_BITS'(x_reg) - OPND_BITS'(y_reg);
                base     = SUM_BITS'(s2_reg);
            end
            STEP_N2:
            begin
                mac_coef = coef_a2_reg;
                mac_opnd = -OPND_BITS'(y_reg);
                base     = SUM_BITS'(x_reg);
            end
            default:
            begin
                mac_coef = coef_a2_reg;
                mac_opnd = OPND_BITS'(x_reg);
                base     = SUM_BITS'(s1_reg);
            end
        endcase
        // multiplier result is already rounded half up and scaled
        sum = base + SUM_BITS'(mac_quot);
    end

    abp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .coef  (mac_coef),
        .opnd  (mac_opnd),
        .done  (mac_done),
        .quot  (mac_quot)
    );

    // datapath registers
    always_comb
    begin
        coef_a1_next    = coef_a1_reg;
        coef_a2_next    = coef_a2_reg;
        s1_next         = s1_reg;
        s2_next         = s2_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        mark_next       = mark_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_mark_next   = out_mark_reg;

        // writes are to arrive only while idle, which the block does not enforce; unknown indexes are dropped
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COEF_A1: coef_a1_next = cfg_data;
                REG_COEF_A2: coef_a2_next = cfg_data;
                default:     ;
            endcase
        end

        if (in_xfer)
        begin
            x_next    = in_ch.sample_in;
            mark_next = in_ch.block_end_in;
        end

        // s1 is last read by the first product, s2 by the second
        if (fin)
        begin
            unique case (step_reg)
                STEP_Y:  y_next  = sat_sample(sum);
                STEP_N1: s1_next = sat_state(sum);
                STEP_N2: s2_next = sat_state(sum);
                default: ;
            endcase
        end

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_valid_next  = 1'b1;
            out_sample_next = y_reg;
            out_mark_next   = mark_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_Y;
            out_valid_reg <= 1'b0;
            coef_a1_reg   <= '0;
            coef_a2_reg   <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            coef_a1_reg   <= coef_a1_next;
            coef_a2_reg   <= coef_a2_next;
            s1_reg        <= s1_next;
            s2_reg        <= s2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        mark_reg       <= mark_next;
        out_sample_reg <= out_sample_next;
        out_mark_reg   <= out_mark_next;
    end

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output state");

    a_fin_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> mac_done)
        else $error("product folded before the multiplier finished");

    a_xfer_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_LOAD) && (step_reg == STEP_Y))
        else $error("input transfer did not start the first product");

endmodule
